FILE: rtl/lz11d_pkg.sv
// ----------------------------------------------------------------------------
// lz11d_pkg
// Shared types and constants for the LZ11 stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lz11d_pkg;

  localparam int unsigned WindowDepth = 4096;
  localparam int unsigned GroupSize   = 8;

  localparam logic [7:0] HeaderFlag = 8'h11;

  // result status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadHeader = 3'd1;
  localparam logic [2:0] StTooFar    = 3'd2;
  localparam logic [2:0] StTruncated = 3'd3;
  localparam logic [2:0] StRefused   = 3'd4;

  // item opcodes
  localparam logic OpFeed = 1'b0;
  localparam logic OpPull = 1'b1;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhExt    = 3'd1,
    PhItem   = 3'd2,
    PhCopy   = 3'd3,
    PhDone   = 3'd4
  } phase_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       copy_pending;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/lz11_if.sv
// ----------------------------------------------------------------------------
// lz11_in_if / lz11_out_if
// Valid/ready channels carrying decompressor requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lz11_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, opcode, in_byte, in_last, input ready);
  modport sink (input valid, opcode, in_byte, in_last, output ready);
endinterface

interface lz11_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       copy_pending;
  logic       done_res;
  logic [2:0] status;
  modport source (output valid, out_byte, out_valid, copy_pending, done_res, status,
                  input ready);
  modport sink (input valid, out_byte, out_valid, copy_pending, done_res, status,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/lz11d_front.sv
// ----------------------------------------------------------------------------
// lz11d_front
// Two-entry request queue between the input channel and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module lz11d_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  lz11_in_if.sink          in_i,
  output logic             q_valid_o,
  output lz11d_pkg::item_t q_item_o,
  input  wire              q_pop_i
);

  lz11d_pkg::item_t slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{opcode: in_i.opcode, in_byte: in_i.in_byte,
                             in_last: in_i.in_last};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lz11d_back.sv
// ----------------------------------------------------------------------------
// lz11d_back
// Decoder state, history window, result reg; one request/cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lz11d_back #(
  parameter int unsigned WINDOW_DEPTH = lz11d_pkg::WindowDepth,
  parameter int unsigned GROUP_SIZE   = lz11d_pkg::GroupSize
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              q_valid_i,
  input  lz11d_pkg::item_t q_item_i,
  output logic             q_pop_o,
  lz11_out_if.source       out_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [3:0]  GroupLimit = 4'(GROUP_SIZE);

  lz11d_pkg::phase_e phase_q, phase_d;
  logic [2:0]  hc_q, hc_d;
  logic [31:0] size_q, size_d;
  logic [31:0] prod_q, prod_d;
  logic [7:0]  flags_q, flags_d;
  logic [3:0]  gidx_q, gidx_d;
  logic [31:0] tok_q, tok_d;
  logic [2:0]  tcnt_q, tcnt_d;
  logic [16:0] rem_q, rem_d;
  logic [12:0] dist_q, dist_d;
  logic [AW-1:0] hp_q, hp_d;
  logic        ended_q, ended_d;
  logic [2:0]  fstat_q, fstat_d;

  logic [7:0]  hist_mem [WINDOW_DEPTH];
  logic [7:0]  rd_data_q, fwd_data_q;
  logic        fwd_q;
  logic [AW-1:0] rd_addr;
  logic        we;
  logic [7:0]  wdata;
  logic [7:0]  pull_byte;

  lz11d_pkg::res_t res, res_q;
  logic        ovld_q;
  logic        fire;

  assign fire      = q_valid_i && (!ovld_q || out_o.ready);
  assign q_pop_o   = fire;
  assign pull_byte = fwd_q ? fwd_data_q : rd_data_q;

  // decode one request
  always_comb begin
    logic [31:0] tnew;
    logic [2:0]  cnew;
    logic [7:0]  first;
    logic [2:0]  need;
    logic [16:0] len;
    logic [31:0] left;
    logic        lit_bit;
    logic        skip_trunc;
    phase_d = phase_q; hc_d = hc_q; size_d = size_q; prod_d = prod_q;
    flags_d = flags_q; gidx_d = gidx_q; tok_d = tok_q; tcnt_d = tcnt_q;
    rem_d = rem_q; dist_d = dist_q; hp_d = hp_q; ended_d = ended_q;
    fstat_d = fstat_q;
    we = 1'b0; wdata = q_item_i.in_byte;
    res = '0;
    tnew = {tok_q[23:0], q_item_i.in_byte};
    cnew = tcnt_q + 3'd1;
    first = 8'(tnew >> {cnew - 3'd1, 3'b000});
    need = (first[7:4] >= 4'd2) ? 3'd2 : ((first[7:4] == 4'd0) ? 3'd3 : 3'd4);
    len = '0; left = '0;
    lit_bit = ~flags_q[3'(4'd7 - gidx_q)];
    skip_trunc = 1'b0;
    if (phase_q == lz11d_pkg::PhDone) begin
      // finished: nothing changes
    end else if (q_item_i.opcode == lz11d_pkg::OpPull) begin
      if (phase_q != lz11d_pkg::PhCopy) begin
        res.status = lz11d_pkg::StRefused;
      end else begin
        res.out_byte  = pull_byte;
        res.out_valid = 1'b1;
        we = 1'b1; wdata = pull_byte;
        hp_d = hp_q + AW'(1);
        prod_d = prod_q + 32'd1;
        rem_d = rem_q - 17'd1;
        if (rem_q == 17'd1) begin
          phase_d = lz11d_pkg::PhItem;
          if (prod_d == size_q) begin
            phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StOk;
          end else if (ended_q) begin
            phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StTruncated;
          end
        end
      end
    end else if (phase_q == lz11d_pkg::PhCopy) begin
      res.status = lz11d_pkg::StRefused;
    end else begin
      ended_d = ended_q | q_item_i.in_last;
      unique case (phase_q)
        lz11d_pkg::PhHeader: begin
          if (hc_q == 3'd0 && q_item_i.in_byte != lz11d_pkg::HeaderFlag) begin
            phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StBadHeader;
          end else begin
            if (hc_q != 3'd0) begin
              size_d = size_q | (32'(q_item_i.in_byte) << {hc_q[1:0] - 2'd1, 3'b000});
            end
            hc_d = hc_q + 3'd1;
            if (hc_d >= 3'd4) begin
              hc_d = 3'd0;
              phase_d = (size_d == 32'd0) ? lz11d_pkg::PhExt : lz11d_pkg::PhItem;
            end
          end
        end
        lz11d_pkg::PhExt: begin
          size_d = size_q | (32'(q_item_i.in_byte) << {hc_q[1:0], 3'b000});
          hc_d = hc_q + 3'd1;
          if (hc_d >= 3'd4) begin
            hc_d = 3'd0;
            if (size_d == 32'd0) begin
              phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StOk;
            end else begin
              phase_d = lz11d_pkg::PhItem;
            end
          end
        end
        default: begin
          if (tcnt_q == 3'd0 && gidx_q >= GroupLimit) begin
            flags_d = q_item_i.in_byte;
            gidx_d = 4'd0;
          end else if (tcnt_q == 3'd0 && lit_bit) begin
            // literal byte
            res.out_byte  = q_item_i.in_byte;
            res.out_valid = 1'b1;
            we = 1'b1;
            hp_d = hp_q + AW'(1);
            prod_d = prod_q + 32'd1;
            gidx_d = gidx_q + 4'd1;
            skip_trunc = 1'b1;
            if (prod_d == size_q) begin
              phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StOk;
            end else if (ended_d) begin
              phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StTruncated;
            end
          end else if (cnew < need) begin
            tok_d = tnew; tcnt_d = cnew;
          end else begin
            // token complete
            if (need == 3'd2) len = 17'(tnew[15:12]) + 17'd1;
            else if (need == 3'd3) len = 17'(tnew[19:12]) + 17'd17;
            else len = 17'(tnew[27:12]) + 17'd273;
            tok_d = '0; tcnt_d = 3'd0;
            gidx_d = gidx_q + 4'd1;
            if (32'(tnew[11:0]) + 32'd1 > prod_q) begin
              phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StTooFar;
            end else begin
              left = size_q - prod_q;
              rem_d = (32'(len) < left) ? len : left[16:0];
              dist_d = 13'(tnew[11:0]) + 13'd1;
              phase_d = lz11d_pkg::PhCopy;
            end
          end
        end
      endcase
      if (!skip_trunc && phase_d != lz11d_pkg::PhDone && phase_d != lz11d_pkg::PhCopy
          && ended_d) begin
        phase_d = lz11d_pkg::PhDone; fstat_d = lz11d_pkg::StTruncated;
      end
    end
    res.copy_pending = (phase_d == lz11d_pkg::PhCopy);
    res.done_res     = (phase_d == lz11d_pkg::PhDone);
    if (phase_d == lz11d_pkg::PhDone) res.status = fstat_d;
  end

  // next copy source address, from the state after this cycle
  assign rd_addr = fire ? (hp_d - dist_d[AW-1:0]) : (hp_q - dist_q[AW-1:0]);

  // history window with one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (fire && we) hist_mem[hp_q] <= wdata;
    rd_data_q  <= hist_mem[rd_addr];
    fwd_data_q <= wdata;
  end

  // forward a byte written in the same cycle it is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= fire && we && (rd_addr == hp_q);
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lz11d_pkg::PhHeader;
      hc_q <= '0; size_q <= '0; prod_q <= '0; flags_q <= '0;
      gidx_q <= GroupLimit; tok_q <= '0; tcnt_q <= '0; rem_q <= '0;
      dist_q <= '0; hp_q <= '0; ended_q <= 1'b0; fstat_q <= lz11d_pkg::StOk;
    end else if (fire) begin
      phase_q <= phase_d;
      hc_q <= hc_d; size_q <= size_d; prod_q <= prod_d; flags_q <= flags_d;
      gidx_q <= gidx_d; tok_q <= tok_d; tcnt_q <= tcnt_d; rem_q <= rem_d;
      dist_q <= dist_d; hp_q <= hp_d; ended_q <= ended_d; fstat_q <= fstat_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (fire) begin
      ovld_q <= 1'b1;
    end else if (out_o.ready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res;
  end

  assign out_o.valid        = ovld_q;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.out_valid    = res_q.out_valid;
  assign out_o.copy_pending = res_q.copy_pending;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.status       = res_q.status;

endmodule

`default_nettype wire

FILE: rtl/lz11_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lz11_stream_decompressor
// LZ11 stream decoder: request queue in front, decoder and history behind.
// ----------------------------------------------------------------------------
// Each request either feeds one compressed byte or pulls the next byte of a
// pending copy, and returns exactly one result. The decoder takes one request
// per clock unless the result register stalls: a copy byte comes out of the
// 4096-byte history memory through a registered read issued a cycle ahead,
// with the just-written byte forwarded when the distance is one, so a copy
// streams at one byte per cycle unless stalled. A two-entry queue in front and
// a result register behind let input and output stall independently.
`default_nettype none

module lz11_stream_decompressor #(
  parameter int unsigned WINDOW_DEPTH = lz11d_pkg::WindowDepth,
  parameter int unsigned GROUP_SIZE   = lz11d_pkg::GroupSize
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lz11_in_if.sink     in_i,
  lz11_out_if.source  out_o
);

  logic             q_valid;
  logic             q_pop;
  lz11d_pkg::item_t q_item;

  lz11d_front u_front (
    .clk_i, .rst_ni, .in_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  lz11d_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .GROUP_SIZE   (GROUP_SIZE)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o
  );

endmodule

`default_nettype wire

FILE: rtl/lz11d_checker.sv
// ----------------------------------------------------------------------------
// lz11d_checker
// Port-level checks on the decompressor result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lz11d_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       valid_i,
  input wire       ready_i,
  input wire [7:0] out_byte_i,
  input wire       out_valid_i,
  input wire       copy_pending_i,
  input wire       done_res_i,
  input wire [2:0] status_i
);

  logic acc;
  logic done_seen_q;

  assign acc = valid_i && ready_i;

  // remember that decoding has finished
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
    end else if (acc && done_res_i) begin
      done_seen_q <= 1'b1;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && done_seen_q |-> done_res_i && !out_valid_i)
    else $error("result after finish not marked done");

  a_copy_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> !(copy_pending_i && done_res_i))
    else $error("copy pending while done");

  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && status_i == lz11d_pkg::StRefused |-> !done_res_i && !out_valid_i)
    else $error("refused request changed output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(out_byte_i) && $stable(status_i))
    else $error("stalled result changed");

endmodule

bind lz11_stream_decompressor lz11d_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (out_o.valid),
  .ready_i        (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .out_valid_i    (out_o.out_valid),
  .copy_pending_i (out_o.copy_pending),
  .done_res_i     (out_o.done_res),
  .status_i       (out_o.status)
);

`default_nettype wire
